// ----- hw/rtl/ftvp_pkg.sv -----
// ----------------------------------------------------------------------------
// ftvp_pkg
// shared types, constants and the message type lookup for the fix parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftvp_pkg;

  // byte constants
  localparam logic [7:0] SOH_BYTE   = 8'h01;
  localparam logic [7:0] EQ_BYTE    = 8'h3d;
  localparam logic [7:0] ZERO_BYTE  = 8'h30;
  localparam logic [7:0] NINE_BYTE  = 8'h39;

  // output widths fixed by the result format, plus the checksum value width and limit
  localparam int unsigned OUT_TAG_W  = 16;
  localparam int unsigned FIELDS_W   = 16;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CKS_W      = 10;
  localparam logic [CKS_W-1:0] CKS_MAX = 10'd1023;
  localparam int unsigned TDATA_W    = 120;

  // bundle queue
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = 2;
  localparam int unsigned QCNT_W     = 3;

  typedef enum logic [1:0] {
    MODE_TAG   = 2'd0,
    MODE_VALUE = 2'd1,
    MODE_SKIP  = 2'd2
  } scan_mode_e;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    MT_UNKNOWN     = 4'd0,
    MT_HEARTBEAT   = 4'd1,
    MT_LOGON       = 4'd2,
    MT_LOGOUT      = 4'd3,
    MT_SNAPSHOT    = 4'd4,
    MT_INCREMENTAL = 4'd5,
    MT_EXECUTION   = 4'd6,
    MT_QUOTE_REQ   = 4'd7,
    MT_NEW_ORDER   = 4'd8
  } msg_type_e;

  // everything one input byte produces: up to three result words
  typedef struct packed {
    logic                  has_val;
    logic                  has_end;
    logic                  has_done;
    logic [OUT_TAG_W-1:0]  tag;
    logic [7:0]            vbyte;
    logic [7:0]            pos_val;
    logic [7:0]            pos_end;
    logic [3:0]            mtype;
    logic [FIELDS_W-1:0]   fields_pre;
    logic [FIELDS_W-1:0]   fields_post;
    logic                  parse_ok;
    logic                  cks_ok;
    logic [COUNT_W-1:0]    good;
    logic [COUNT_W-1:0]    bad;
  } bundle_t;

  function automatic msg_type_e classify(input logic [7:0] c);
    msg_type_e r;
    case (c)
      8'h30:   r = MT_HEARTBEAT;   // '0'
      8'h41:   r = MT_LOGON;       // 'A'
      8'h35:   r = MT_LOGOUT;      // '5'
      8'h57:   r = MT_SNAPSHOT;    // 'W'
      8'h58:   r = MT_INCREMENTAL; // 'X'
      8'h38:   r = MT_EXECUTION;   // '8'
      8'h52:   r = MT_QUOTE_REQ;   // 'R'
      8'h44:   r = MT_NEW_ORDER;   // 'D'
      default: r = MT_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/ftvp_front.sv -----
// ----------------------------------------------------------------------------
// ftvp_front
// byte scanner: tracks tag/value state and builds one result bundle per byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftvp_front #(
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             byte_valid_i,
  output logic             byte_ready_o,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  input  logic             q_full_i,
  output logic             push_o,
  output ftvp_pkg::bundle_t bundle_o
);

  localparam logic [TAG_WIDTH-1:0] TagMax = {TAG_WIDTH{1'b1}};
  localparam int unsigned CKS_W = ftvp_pkg::CKS_W;
  localparam int unsigned FW    = ftvp_pkg::FIELDS_W;
  localparam int unsigned CW    = ftvp_pkg::COUNT_W;

  ftvp_pkg::scan_mode_e   mode_q, mode_d;
  logic [TAG_WIDTH-1:0]   tag_q, tag_d;
  logic [7:0]             voff_q, voff_d;
  logic                   err_q, err_d;
  ftvp_pkg::msg_type_e    type_q, type_d;
  ftvp_pkg::msg_type_e    type_row;
  logic [7:0]             sum_q, sum_d;
  logic [7:0]             start_q, start_d;
  logic                   seen_q, seen_d;
  logic [CKS_W-1:0]       cks_q, cks_d;
  logic [FW-1:0]          ft_q, ft_d;
  logic [CW-1:0]          good_q, good_d;
  logic [CW-1:0]          bad_q, bad_d;
  logic                   req_q;

  logic                   accept;
  logic                   is_digit;
  logic [3:0]             dig;
  logic [TAG_WIDTH+3:0]   tag_mul;
  logic [CKS_W+3:0]       cks_mul;
  logic [7:0]             off_inc;
  logic                   has_val, has_end, has_done;
  logic [7:0]             pos_end;
  logic [FW-1:0]          ft_post;
  logic                   cok, pok;

  assign byte_ready_o = !q_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  assign is_digit = (byte_i inside {[ftvp_pkg::ZERO_BYTE:ftvp_pkg::NINE_BYTE]});
  assign dig      = 4'(byte_i - ftvp_pkg::ZERO_BYTE);
  // times ten as two shifts and an add
  assign tag_mul  = ({4'b0, tag_q} << 3) + ({4'b0, tag_q} << 1)
                  + (TAG_WIDTH+4)'(dig);
  assign cks_mul  = ({4'b0, cks_q} << 3) + ({4'b0, cks_q} << 1)
                  + (CKS_W+4)'(dig);
  assign off_inc  = (voff_q == 8'hff) ? voff_q : voff_q + 8'd1;

  always_comb begin
    mode_d   = mode_q;
    tag_d    = tag_q;
    voff_d   = voff_q;
    err_d    = err_q;
    type_d   = type_q;
    sum_d    = sum_q;
    start_d  = start_q;
    seen_d   = seen_q;
    cks_d    = cks_q;
    good_d   = good_q;
    bad_d    = bad_q;
    has_val  = 1'b0;
    has_end  = 1'b0;
    has_done = 1'b0;
    pos_end  = 8'd0;

    if (accept) begin
      if (!seen_q) begin
        sum_d = sum_q + byte_i;
      end
      case (mode_q)
        ftvp_pkg::MODE_TAG: begin
          if (is_digit) begin
            tag_d = (tag_mul > {4'b0, TagMax}) ? TagMax : tag_mul[TAG_WIDTH-1:0];
            if (last_i) begin
              err_d = 1'b1;
            end
          end else if (byte_i == ftvp_pkg::EQ_BYTE) begin
            if (tag_q == TAG_WIDTH'(10)) begin
              // byte sum freezes at the first checksum field
              if (!seen_q) begin
                sum_d  = start_q;
                seen_d = 1'b1;
              end
              cks_d = '0;
            end
            mode_d = ftvp_pkg::MODE_VALUE;
            voff_d = 8'd0;
            has_end = last_i;
          end else begin
            err_d  = 1'b1;
            mode_d = ftvp_pkg::MODE_SKIP;
          end
        end
        ftvp_pkg::MODE_VALUE: begin
          if (byte_i == ftvp_pkg::SOH_BYTE) begin
            has_end = 1'b1;
            pos_end = voff_q;
            mode_d  = ftvp_pkg::MODE_TAG;
            tag_d   = '0;
            voff_d  = 8'd0;
            start_d = sum_d;
          end else begin
            if (tag_q == TAG_WIDTH'(35) && voff_q == 8'd0) begin
              type_d = ftvp_pkg::classify(byte_i);
            end
            if (tag_q == TAG_WIDTH'(10)) begin
              if (is_digit) begin
                cks_d = (cks_mul > {4'b0, ftvp_pkg::CKS_MAX}) ? ftvp_pkg::CKS_MAX
                                                              : cks_mul[CKS_W-1:0];
              end else begin
                cks_d = ftvp_pkg::CKS_MAX;
              end
            end
            has_val = 1'b1;
            voff_d  = off_inc;
            has_end = last_i;
            pos_end = off_inc;
          end
        end
        default: ;
      endcase
      has_done = last_i;
    end

    // rows of this byte carry the type before the end-of-message clear
    type_row = type_d;
    ft_post  = (has_end && ft_q != {FW{1'b1}}) ? ft_q + FW'(1) : ft_q;
    ft_d     = ft_post;
    cok      = seen_d && (cks_d == {2'b0, sum_d});
    pok      = !err_d && (!req_q || cok);

    if (has_done) begin
      if (pok) begin
        good_d = good_q + CW'(1);
      end else begin
        bad_d = bad_q + CW'(1);
      end
      // per-message state back to its idle values
      mode_d  = ftvp_pkg::MODE_TAG;
      tag_d   = '0;
      voff_d  = 8'd0;
      err_d   = 1'b0;
      type_d  = ftvp_pkg::MT_UNKNOWN;
      sum_d   = 8'd0;
      start_d = 8'd0;
      seen_d  = 1'b0;
      cks_d   = '0;
      ft_d    = '0;
    end
  end

  assign push_o = has_val || has_end || has_done;

  always_comb begin
    bundle_o.has_val     = has_val;
    bundle_o.has_end     = has_end;
    bundle_o.has_done    = has_done;
    bundle_o.tag         = ftvp_pkg::OUT_TAG_W'(tag_q);
    bundle_o.vbyte       = byte_i;
    bundle_o.pos_val     = voff_q;
    bundle_o.pos_end     = pos_end;
    bundle_o.mtype       = type_row;
    bundle_o.fields_pre  = ft_q;
    bundle_o.fields_post = ft_post;
    bundle_o.parse_ok    = pok;
    bundle_o.cks_ok      = cok;
    bundle_o.good        = good_q;
    bundle_o.bad         = bad_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ftvp_pkg::MODE_TAG;
      tag_q   <= '0;
      voff_q  <= 8'd0;
      err_q   <= 1'b0;
      type_q  <= ftvp_pkg::MT_UNKNOWN;
      sum_q   <= 8'd0;
      start_q <= 8'd0;
      seen_q  <= 1'b0;
      cks_q   <= '0;
      ft_q    <= '0;
      good_q  <= '0;
      bad_q   <= '0;
      req_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      tag_q   <= tag_d;
      voff_q  <= voff_d;
      err_q   <= err_d;
      type_q  <= type_d;
      sum_q   <= sum_d;
      start_q <= start_d;
      seen_q  <= seen_d;
      cks_q   <= cks_d;
      ft_q    <= ft_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
      if (cfg_we_i) begin
        req_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ----- hw/rtl/ftvp_queue.sv -----
// ----------------------------------------------------------------------------
// ftvp_queue
// short fifo of result bundles between the scanner and the word emitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftvp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ftvp_pkg::bundle_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ftvp_pkg::bundle_t rdata_o
);

  localparam int unsigned PW = ftvp_pkg::QPTR_W;
  localparam int unsigned NW = ftvp_pkg::QCNT_W;

  ftvp_pkg::bundle_t mem_q [ftvp_pkg::QDEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(ftvp_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + PW'(1) : wptr_q;
    rptr_d = do_pop  ? rptr_q + PW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/ftvp_back.sv -----
// ----------------------------------------------------------------------------
// ftvp_back
// word emitter: walks the rows of the head bundle into a registered output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftvp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  ftvp_pkg::bundle_t            q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ftvp_pkg::TDATA_W-1:0] out_data_o,
  output logic [1:0]                   out_user_o,
  output logic                         out_last_o
);

  localparam int unsigned CW = ftvp_pkg::COUNT_W;

  logic [2:0]  sent_q, sent_d;
  logic        vld_q, vld_d;
  logic [ftvp_pkg::TDATA_W-1:0] data_q;
  logic [1:0]  user_q;
  logic        last_q;

  logic [2:0]  present, remain, pick;
  logic        row_last, load;
  ftvp_pkg::kind_e kind;
  logic [15:0] r_tag;
  logic [7:0]  r_vb, r_pos;
  logic        r_pok, r_cok;
  logic [15:0] r_fields;
  logic [CW-1:0] r_good, r_bad;
  logic [ftvp_pkg::TDATA_W-1:0] r_data;

  assign present  = {q_data_i.has_done, q_data_i.has_end, q_data_i.has_val};
  assign remain   = present & ~sent_q;
  assign pick     = remain & (~remain + 3'd1); // lowest pending row
  assign row_last = ((remain & ~pick) == 3'b000);
  assign load     = q_valid_i && (!vld_q || out_ready_i);
  assign q_pop_o  = load && row_last;

  always_comb begin
    kind     = ftvp_pkg::KIND_DONE;
    r_tag    = 16'd0;
    r_vb     = 8'd0;
    r_pos    = 8'd0;
    r_pok    = 1'b0;
    r_cok    = 1'b0;
    r_fields = q_data_i.fields_pre;
    r_good   = q_data_i.good;
    r_bad    = q_data_i.bad;
    if (pick[0]) begin
      kind  = ftvp_pkg::KIND_VALUE;
      r_tag = q_data_i.tag;
      r_vb  = q_data_i.vbyte;
      r_pos = q_data_i.pos_val;
    end else if (pick[1]) begin
      kind  = ftvp_pkg::KIND_FIELD;
      r_tag = q_data_i.tag;
      r_pos = q_data_i.pos_end;
    end else begin
      r_pok    = q_data_i.parse_ok;
      r_cok    = q_data_i.cks_ok;
      r_fields = q_data_i.fields_post;
      r_good   = q_data_i.good + CW'(q_data_i.parse_ok);
      r_bad    = q_data_i.bad + CW'(!q_data_i.parse_ok);
    end
    r_data = {2'b00, r_bad, r_good, r_fields, r_cok, r_pok, q_data_i.mtype,
              r_pos, r_vb, r_tag};
  end

  always_comb begin
    sent_d = sent_q;
    vld_d  = vld_q;
    if (load) begin
      vld_d  = 1'b1;
      sent_d = row_last ? 3'b000 : (sent_q | pick);
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= 3'b000;
      vld_q  <= 1'b0;
    end else begin
      sent_q <= sent_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= r_data;
      user_q <= kind;
      last_q <= row_last;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

endmodule

// ----- hw/rtl/fix_tag_value_stream_parser_core.sv -----
// ----------------------------------------------------------------------------
// fix_tag_value_stream_parser_core
// fix tag=value byte stream parser with checksum check and message typing
// ----------------------------------------------------------------------------
// a byte's result words pass the bundle queue, then the output register, onto m_axis
// throughput: one input byte per cycle while the bundle queue has room; one
//   result word per cycle out while m_axis_tready is high, so a byte making 2 or
//   3 words keeps the emitter on it and the 4-entry queue absorbs the bursts
// reset: rst_ni clears parse state, counters, the checksum_required register
//   and the queue at once; no clearing pass
`timescale 1ns / 1ps

module fix_tag_value_stream_parser_core #(
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: checksum_required
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  // input byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_message
  // result words
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] field_tag, [23:16] value_byte, [31:24] value_position,
  // [35:32] message_type, [36] parse_ok, [37] checksum_ok,
  // [53:38] fields_seen, [85:54] good_messages, [117:86] bad_messages,
  // [119:118] zero
  output logic [119:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  output logic         m_axis_tlast    // last_of_run
);

  // front: scanner state machine turns each byte into a bundle of up to
  // three result rows (value byte, field end, message done)
  // queue: decouples the scanner, one byte per cycle unless full, from the emitter
  // back: steps through the rows of each bundle into an output register

  ftvp_pkg::bundle_t push_bundle;
  ftvp_pkg::bundle_t head_bundle;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;

  ftvp_front #(
    .TAG_WIDTH (TAG_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .q_full_i     (q_full),
    .push_o       (push),
    .bundle_o     (push_bundle)
  );

  ftvp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_bundle),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (head_bundle)
  );

  ftvp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (head_bundle),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- tb/fix_tag_value_stream_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// fix_tag_value_stream_parser_core_tb
// self-checking bench for the fix tag=value parser: a directed table of short
// messages, then random well-formed, broken and noise messages under random
// backpressure, each result word checked against a parser model in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fix_tag_value_stream_parser_core_tb;

  localparam int unsigned TAG_W       = 16;
  localparam int unsigned TAG_MAX     = (1 << TAG_W) - 1;
  localparam int unsigned CKS_LIMIT   = ftvp_pkg::CKS_MAX;
  localparam int unsigned CKS_TAG     = 10;
  localparam int unsigned TYPE_TAG    = 35;
  localparam int          HOLD_CYCLES = 200;

  // one expected result word
  typedef struct {
    ftvp_pkg::kind_e kind;
    logic [15:0] tag;
    logic [7:0]  vbyte;
    logic [7:0]  pos;
    logic [3:0]  mtype;
    logic        pok;
    logic        cok;
    logic [15:0] fields;
    logic [31:0] good;
    logic [31:0] bad;
    logic        last;
  } result_word_t;

  // one row of the directed table; typed rows carry the message-done verdict
  typedef struct {
    logic [7:0]  data;
    logic        eom;
    logic        typed;
    logic        pok;
    logic        cok;
    logic [31:0] good;
    logic [31:0] bad;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic         cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // which directed row is on the bus, -1 for random traffic
  int           row_sel;

  // parser model state
  ftvp_pkg::scan_mode_e mode;
  int unsigned  tag_acc;
  logic [7:0]   val_off;
  logic         err;
  ftvp_pkg::msg_type_e  mtype_now;
  logic [7:0]   bsum;
  logic [7:0]   sum_field_start;
  logic         cks_seen;
  int unsigned  cks_val;
  logic [15:0]  nfields;
  logic [31:0]  ngood;
  logic [31:0]  nbad;
  logic         cks_req;

  // words caused by the byte being modeled, then the queue of words owed
  result_word_t run_buf [3];
  int           run_len;
  result_word_t words_due [$];

  stim_row_t    directed_rows [$];
  logic [7:0]   msg_q [$];

  logic         tx_calm  = 1'b0;
  logic         rx_calm  = 1'b0;
  logic         hold_req = 1'b0;
  int           fail_count    = 0;
  int           words_checked = 0;
  int           msgs_done     = 0;
  int           live_bytes    = 0;
  int           long_holds    = 0;

  fix_tag_value_stream_parser_core #(
    .TAG_WIDTH(TAG_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic ftvp_pkg::msg_type_e type_from_byte(input logic [7:0] c);
    case (c)
      "0":     return ftvp_pkg::MT_HEARTBEAT;
      "A":     return ftvp_pkg::MT_LOGON;
      "5":     return ftvp_pkg::MT_LOGOUT;
      "W":     return ftvp_pkg::MT_SNAPSHOT;
      "X":     return ftvp_pkg::MT_INCREMENTAL;
      "8":     return ftvp_pkg::MT_EXECUTION;
      "R":     return ftvp_pkg::MT_QUOTE_REQ;
      "D":     return ftvp_pkg::MT_NEW_ORDER;
      default: return ftvp_pkg::MT_UNKNOWN;
    endcase
  endfunction

  task automatic start_new_message();
    mode            = ftvp_pkg::MODE_TAG;
    tag_acc         = 0;
    val_off         = '0;
    err             = 1'b0;
    mtype_now       = ftvp_pkg::MT_UNKNOWN;
    bsum            = '0;
    sum_field_start = '0;
    cks_seen        = 1'b0;
    cks_val         = 0;
    nfields         = '0;
  endtask

  task automatic emit(input ftvp_pkg::kind_e k, input logic [15:0] tg,
                      input logic [7:0] vb, input logic [7:0] ps, input logic pok,
                      input logic cok);
    run_buf[run_len].kind   = k;
    run_buf[run_len].tag    = tg;
    run_buf[run_len].vbyte  = vb;
    run_buf[run_len].pos    = ps;
    run_buf[run_len].mtype  = mtype_now;
    run_buf[run_len].pok    = pok;
    run_buf[run_len].cok    = cok;
    run_buf[run_len].fields = nfields;
    run_buf[run_len].good   = ngood;
    run_buf[run_len].bad    = nbad;
    run_buf[run_len].last   = 1'b0;
    run_len++;
  endtask

  task automatic close_field();
    emit(ftvp_pkg::KIND_FIELD, tag_acc[15:0], 8'h00, val_off, 1'b0, 1'b0);
    if (nfields != 16'hFFFF) nfields++;
  endtask

  // advance the parser model by one accepted byte, queue the words it owes
  task automatic parse_byte(input logic [7:0] b, input logic eom);
    int unsigned d;
    logic        cok;
    logic        pok;
    run_len = 0;
    if (!cks_seen) bsum = bsum + b;
    case (mode)
      ftvp_pkg::MODE_TAG: begin
        if (b >= ftvp_pkg::ZERO_BYTE && b <= ftvp_pkg::NINE_BYTE) begin
          d = 32'(b - ftvp_pkg::ZERO_BYTE);
          tag_acc = (tag_acc > (TAG_MAX - d) / 10) ? TAG_MAX : tag_acc * 10 + d;
          if (eom) err = 1'b1;
        end else if (b == ftvp_pkg::EQ_BYTE) begin
          // first checksum field freezes the sum at the start of that field
          if (tag_acc == CKS_TAG) begin
            if (!cks_seen) begin
              bsum     = sum_field_start;
              cks_seen = 1'b1;
            end
            cks_val = 0;
          end
          mode    = ftvp_pkg::MODE_VALUE;
          val_off = '0;
          if (eom) close_field();
        end else begin
          err  = 1'b1;
          mode = ftvp_pkg::MODE_SKIP;
        end
      end
      ftvp_pkg::MODE_VALUE: begin
        if (b == ftvp_pkg::SOH_BYTE) begin
          close_field();
          mode            = ftvp_pkg::MODE_TAG;
          tag_acc         = 0;
          val_off         = '0;
          sum_field_start = bsum;
        end else begin
          if (tag_acc == TYPE_TAG && val_off == 0) mtype_now = type_from_byte(b);
          if (tag_acc == CKS_TAG) begin
            if (b >= ftvp_pkg::ZERO_BYTE && b <= ftvp_pkg::NINE_BYTE) begin
              d = 32'(b - ftvp_pkg::ZERO_BYTE);
              cks_val = (cks_val > (CKS_LIMIT - d) / 10) ? CKS_LIMIT : cks_val * 10 + d;
            end else begin
              cks_val = CKS_LIMIT;
            end
          end
          emit(ftvp_pkg::KIND_VALUE, tag_acc[15:0], b, val_off, 1'b0, 1'b0);
          if (val_off != 8'hFF) val_off++;
          if (eom) close_field();
        end
      end
      default: ;
    endcase
    if (eom) begin
      cok = cks_seen && (cks_val == bsum);
      pok = !err && (!cks_req || cok);
      if (pok) ngood++;
      else nbad++;
      emit(ftvp_pkg::KIND_DONE, 16'h0000, 8'h00, 8'h00, pok, cok);
      start_new_message();
    end
    if (run_len > 0) run_buf[run_len - 1].last = 1'b1;
    for (int i = 0; i < run_len; i++) words_due.push_back(run_buf[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // ------------------------------------------------------------ scoreboard
  // outputs are checked before the model steps, so a word is never matched
  // against a prediction made at the same edge
  always @(posedge clk_i) begin : scoreboard
    result_word_t w;
    if (!rst_ni) begin
      ngood = '0;
      nbad  = '0;
      start_new_message();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (words_due.size() == 0) begin
          $error("result word with nothing expected: kind %0d", m_axis_tuser);
          fail_count++;
        end else begin
          w = words_due.pop_front();
          check_field("kind",           w.kind,   m_axis_tuser);
          check_field("field_tag",      w.tag,    m_axis_tdata[15:0]);
          check_field("value_byte",     w.vbyte,  m_axis_tdata[23:16]);
          check_field("value_position", w.pos,    m_axis_tdata[31:24]);
          check_field("message_type",   w.mtype,  m_axis_tdata[35:32]);
          check_field("parse_ok",       w.pok,    m_axis_tdata[36]);
          check_field("checksum_ok",    w.cok,    m_axis_tdata[37]);
          check_field("fields_seen",    w.fields, m_axis_tdata[53:38]);
          check_field("good_messages",  w.good,   m_axis_tdata[85:54]);
          check_field("bad_messages",   w.bad,    m_axis_tdata[117:86]);
          check_field("last_of_run",    w.last,   m_axis_tlast);
          words_checked++;
          if (w.kind == ftvp_pkg::KIND_DONE) msgs_done++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (mode != ftvp_pkg::MODE_SKIP) live_bytes++;
        parse_byte(s_axis_tdata, s_axis_tlast);
        // directed rows with a hand-written verdict on the message-done word
        if (row_sel >= 0) begin
          if (directed_rows[row_sel].typed) begin
            w = run_buf[run_len - 1];
            check_field("kind",          ftvp_pkg::KIND_DONE,        w.kind);
            check_field("parse_ok",      directed_rows[row_sel].pok,  w.pok);
            check_field("checksum_ok",   directed_rows[row_sel].cok,  w.cok);
            check_field("good_messages", directed_rows[row_sel].good, w.good);
            check_field("bad_messages",  directed_rows[row_sel].bad,  w.bad);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------- idling

  // mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // output side: random stalls, calm stretches, and one long hold on request
  initial begin
    int   stall_left;
    int   ticks;
    logic hold_taken;
    stall_left    = 0;
    ticks         = 0;
    hold_taken    = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      ticks++;
      if (ticks % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES;
        long_holds++;
      end else if (stall_left == 0 && !rx_calm && $urandom_range(0, 4) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------- driving

  // offer one byte, hold it until accepted, then maybe idle a while
  task automatic send_byte(input logic [7:0] b, input logic eom, input int sel);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eom;
    row_sel       <= sel;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gap = tx_calm ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering, let every owed word arrive, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_checksum_required(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cks_req      = v;
  endtask

  task automatic add_row(input logic [7:0] b, input logic eom, input logic typed,
                         input logic pok, input logic cok, input logic [31:0] good,
                         input logic [31:0] bad);
    stim_row_t r;
    r.data  = b;
    r.eom   = eom;
    r.typed = typed;
    r.pok   = pok;
    r.cok   = cok;
    r.good  = good;
    r.bad   = bad;
    directed_rows.push_back(r);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
  endtask

  // ------------------------------------------------------ message builder

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic put_num(input int unsigned v);
    put_str($sformatf("%0d", v));
  endtask

  function automatic logic [7:0] type_char();
    case ($urandom_range(0, 8))
      0:       return "0";
      1:       return "A";
      2:       return "5";
      3:       return "W";
      4:       return "X";
      5:       return "8";
      6:       return "R";
      7:       return "D";
      default: return "Z";
    endcase
  endfunction

  // any byte but SOH, weighted toward printable text and digits
  function automatic logic [7:0] value_byte();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 50) v = $urandom_range(32, 126);
    else if (r < 75) v = $urandom_range(48, 57);
    else begin
      v = $urandom_range(0, 254);
      if (v != 0) v++;
    end
    return v[7:0];
  endfunction

  task automatic append_field();
    int r;
    int len;
    r   = $urandom_range(0, 99);
    len = $urandom_range(0, 6);
    if (r < 25) begin
      put_str("35=");
      if (len > 0 && $urandom_range(0, 9) < 7) begin
        msg_q.push_back(type_char());
        len--;
      end
    end else if (r < 32) begin
      put_str("=");
    end else if (r < 38) begin
      // tag near or past the saturation point
      put_num($urandom_range(65530, 999999));
      put_str("=");
    end else if (r < 42) begin
      // early checksum field, later fields leave the sum frozen
      put_str("10=");
    end else begin
      put_num($urandom_range(1, 999));
      put_str("=");
    end
    repeat (len) msg_q.push_back(value_byte());
    msg_q.push_back(ftvp_pkg::SOH_BYTE);
  endtask

  task automatic add_checksum();
    logic [7:0] cs;
    int         r;
    cs = '0;
    foreach (msg_q[i]) cs += msg_q[i];
    put_str("10=");
    r = $urandom_range(0, 99);
    if (r < 70) put_num(cs);
    else if (r < 80) put_num(8'(cs + $urandom_range(1, 255)));
    else if (r < 87) put_str("1X");
    else if (r < 93) put_num($urandom_range(1000, 99999));
    if ($urandom_range(0, 3) != 0) msg_q.push_back(ftvp_pkg::SOH_BYTE);
    // repeated checksum field restarts the value but not the sum
    if ($urandom_range(0, 9) == 0) begin
      if (msg_q[msg_q.size() - 1] != ftvp_pkg::SOH_BYTE) begin
        msg_q.push_back(ftvp_pkg::SOH_BYTE);
      end
      put_str("10=");
      put_num(cs);
      msg_q.push_back(ftvp_pkg::SOH_BYTE);
    end
  endtask

  task automatic build_message(input logic with_long);
    int         style;
    int         k;
    int         cut;
    logic [7:0] nb;
    msg_q.delete();
    style = $urandom_range(0, 99);
    if (style < 8) begin
      // raw noise
      k = $urandom_range(1, 8);
      repeat (k) begin
        nb = 8'($urandom_range(0, 255));
        msg_q.push_back(nb);
      end
    end else begin
      repeat ($urandom_range(1, 4)) append_field();
      if (with_long) begin
        // one value long enough to saturate the byte offset
        put_str("58=");
        repeat (262) begin
          nb = 8'($urandom_range(32, 126));
          msg_q.push_back(nb);
        end
        msg_q.push_back(ftvp_pkg::SOH_BYTE);
      end
      if ($urandom_range(0, 99) < 75) add_checksum();
      if (style < 22) begin
        k = $urandom_range(0, 2);
        if (k == 1) begin
          put_num($urandom_range(0, 99));
        end else begin
          cut = $urandom_range(1, msg_q.size());
          while (msg_q.size() > cut) void'(msg_q.pop_back());
          if (k == 2) begin
            msg_q.push_back(value_byte());
            put_str("5=1");
          end
        end
      end
    end
  endtask

  task automatic run_random(input int target, input logic with_long);
    int   start_count;
    logic want_long;
    start_count = live_bytes;
    want_long   = with_long;
    while (live_bytes - start_count < target) begin
      build_message(want_long);
      want_long = 1'b0;
      tx_calm   = ($urandom_range(0, 3) == 0);
      foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1, -1);
    end
  endtask

  // ------------------------------------------------------------- sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    row_sel       = -1;
    cks_req       = 1'b0;

    // directed table, register still at its reset value
    // bad byte in a tag
    add_row("X", 1'b1, 1'b1, 1'b0, 1'b0, 0, 1);
    // empty tag ending on '='
    add_row("=", 1'b1, 1'b1, 1'b1, 1'b0, 1, 1);
    // message ends inside a tag
    add_row("5", 1'b1, 1'b1, 1'b0, 1'b0, 1, 2);
    // empty type field, then a new order, then a saturated tag ending in a value
    add_text("35=");
    add_row(ftvp_pkg::SOH_BYTE, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
    add_text("35=D");
    add_row(ftvp_pkg::SOH_BYTE, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
    add_text("70000=");
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 2, 2);
    // zero byte in a value, then a matching checksum: '=' + 0x00 + SOH = 62
    add_text("=");
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
    add_row(ftvp_pkg::SOH_BYTE, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
    add_text("10=6");
    add_row("2", 1'b1, 1'b1, 1'b1, 1'b1, 3, 2);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_byte(directed_rows[i].data, directed_rows[i].eom, i);
    drain();

    set_checksum_required(1'b1);
    run_random(40, 1'b0);
    drain();

    set_checksum_required(1'b0);
    run_random(180, 1'b1);
    drain();

    // long output hold while input keeps coming, so the input side backs up
    set_checksum_required(1'b1);
    hold_req = 1'b1;
    run_random(60, 1'b0);
    drain();

    $display("run covered %0d parsed bytes, %0d messages, %0d result words checked",
             live_bytes, msgs_done, words_checked);
    $display("checksum enforcement off and on, tag and offset saturation, %0d long hold(s)",
             long_holds);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
